// ===== rtl/x86e_pkg.sv =====
// Shared types and constants for the x86-64 instruction encoder.
// Holds the command codes, opcode bytes and the encode descriptor passed
// from the front classifier through the queue to the byte serializer.
package x86e_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        CMD_MOVRR    = 4'd0,
        CMD_MOVIMM64 = 4'd1,
        CMD_ADDRR    = 4'd2,
        CMD_ADDIMM   = 4'd3,
        CMD_SUBRR    = 4'd4,
        CMD_SUBIMM   = 4'd5,
        CMD_CMP      = 4'd6,
        CMD_CALLREG  = 4'd7,
        CMD_CALLREL  = 4'd8,
        CMD_RET      = 4'd9,
        CMD_PUSH     = 4'd10,
        CMD_POP      = 4'd11,
        CMD_JCC      = 4'd12,
        CMD_JMP      = 4'd13,
        CMD_STORE    = 4'd14,
        CMD_LOAD     = 4'd15
    } cmd_t;

    localparam logic [7:0] OP_MOV_STORE = 8'h89;
    localparam logic [7:0] OP_ADD_RR    = 8'h01;
    localparam logic [7:0] OP_SUB_RR    = 8'h29;
    localparam logic [7:0] OP_CMP_RR    = 8'h3B;
    localparam logic [7:0] OP_ALU_IMM   = 8'h81;
    localparam logic [7:0] OP_MOV_LOAD  = 8'h8B;
    localparam logic [7:0] OP_GRP5      = 8'hFF;
    localparam logic [7:0] OP_CALL_REL  = 8'hE8;
    localparam logic [7:0] OP_JMP_REL   = 8'hE9;
    localparam logic [7:0] OP_RET       = 8'hC3;
    localparam logic [7:0] OP_ESCAPE    = 8'h0F;
    localparam logic [7:0] SIB_RSP_BASE = 8'h24;
    localparam logic [7:0] REX_B_ONLY   = 8'h41;
    localparam logic [4:0] OP_MOVIMM_HI = 5'b10111;
    localparam logic [4:0] OP_PUSH_HI   = 5'b01010;
    localparam logic [4:0] OP_POP_HI    = 5'b01011;
    localparam logic [3:0] OP_JCC_HI    = 4'h8;
    localparam logic [3:0] REX_HI       = 4'h4;
    localparam logic [2:0] RM_SIB       = 3'd4;
    localparam logic [2:0] EXT_ADD      = 3'd0;
    localparam logic [2:0] EXT_CALL     = 3'd2;
    localparam logic [2:0] EXT_SUB      = 3'd5;
    localparam logic [1:0] MOD_REG      = 2'b11;
    localparam logic [1:0] MOD_DISP8    = 2'b01;

    typedef struct packed {
        logic [63:0] imm;
        logic [3:0]  imm_len;
        logic [31:0] hdr;
        logic [2:0]  hdr_len;
    } desc_t;

endpackage

// ===== rtl/x86_64_instruction_encoder_top.sv =====
// x86-64 instruction encoder, one request in, one code byte per output word.
// An instruction of n bytes (1 to 10) leaves as n output words; the
// single-byte output register sets the pace, so sustained throughput is one
// byte per cycle while m_tready is high. Requests are classified on entry
// and held in a descriptor queue of QUEUE_DEPTH entries, so input and output
// stall independently; the last byte of each instruction carries m_tlast.
// From accept, a request is held in a queue entry, then hdr_reg, then m_tdata_reg.
// Depends on x86e_pkg, x86e_front, x86e_queue and x86e_back.
module x86_64_instruction_encoder_top #(
    parameter int QUEUE_DEPTH = x86e_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // command, rm_register, reg_register, condition, immediate
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // code_byte
    output logic        m_tlast
);

    x86e_pkg::desc_t front_desc;
    x86e_pkg::desc_t back_desc;
    logic            front_valid;
    logic            front_ready;
    logic            back_valid;
    logic            back_ready;

    x86e_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .desc_valid (front_valid),
        .desc_ready (front_ready),
        .desc       (front_desc)
    );

    x86e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_desc   (front_desc),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_desc  (back_desc)
    );

    x86e_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (back_valid),
        .q_ready  (back_ready),
        .q_desc   (back_desc),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/x86e_front.sv =====
// Front classifier: unpacks a request word and builds the encode descriptor
// (prefix/opcode/ModRM/SIB header plus immediate bytes). Uses x86e_pkg.
module x86e_front (
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [79:0]     s_tdata,  // command, rm_register, reg_register, condition, immediate
    output logic            desc_valid,
    input  logic            desc_ready,
    output x86e_pkg::desc_t desc
);

    logic [3:0]  command;
    logic [3:0]  rm_register;
    logic [3:0]  reg_register;
    logic [3:0]  condition;
    logic [63:0] immediate;
    logic [2:0]  m;
    logic [2:0]  r;
    logic        bb;
    logic        rb;
    logic [7:0]  rex_wrb;
    logic [7:0]  rex_wb;
    logic [7:0]  modrm_rr;
    logic [7:0]  modrm_mem;

    assign command      = s_tdata[3:0];
    assign rm_register  = s_tdata[7:4];
    assign reg_register = s_tdata[11:8];
    assign condition    = s_tdata[15:12];
    assign immediate    = s_tdata[79:16];

    assign m  = rm_register[2:0];
    assign r  = reg_register[2:0];
    assign bb = rm_register[3];
    assign rb = reg_register[3];

    assign rex_wrb   = {x86e_pkg::REX_HI, 1'b1, rb, 1'b0, bb};
    assign rex_wb    = {x86e_pkg::REX_HI, 1'b1, 1'b0, 1'b0, bb};
    assign modrm_rr  = {x86e_pkg::MOD_REG, r, m};
    assign modrm_mem = {x86e_pkg::MOD_DISP8, r, m};

    assign desc_valid = s_tvalid;
    assign s_tready   = desc_ready;

    always_comb begin
        desc.imm     = immediate;
        desc.imm_len = 4'd4;
        desc.hdr     = '0;
        desc.hdr_len = 3'd1;
        unique case (x86e_pkg::cmd_t'(command))
            x86e_pkg::CMD_MOVRR: begin
                desc.hdr     = {8'h00, modrm_rr, x86e_pkg::OP_MOV_STORE, rex_wrb};
                desc.hdr_len = 3'd3;
                desc.imm_len = 4'd0;
            end
            x86e_pkg::CMD_ADDRR: begin
                desc.hdr     = {8'h00, modrm_rr, x86e_pkg::OP_ADD_RR, rex_wrb};
                desc.hdr_len = 3'd3;
                desc.imm_len = 4'd0;
            end
            x86e_pkg::CMD_SUBRR: begin
                desc.hdr     = {8'h00, modrm_rr, x86e_pkg::OP_SUB_RR, rex_wrb};
                desc.hdr_len = 3'd3;
                desc.imm_len = 4'd0;
            end
            x86e_pkg::CMD_CMP: begin
                desc.hdr     = {8'h00, modrm_rr, x86e_pkg::OP_CMP_RR, rex_wrb};
                desc.hdr_len = 3'd3;
                desc.imm_len = 4'd0;
            end
            x86e_pkg::CMD_MOVIMM64: begin
                desc.hdr     = {16'h0000, x86e_pkg::OP_MOVIMM_HI, m, rex_wb};
                desc.hdr_len = 3'd2;
                desc.imm_len = 4'd8;
            end
            x86e_pkg::CMD_ADDIMM: begin
                desc.hdr     = {8'h00, x86e_pkg::MOD_REG, x86e_pkg::EXT_ADD, m,
                                x86e_pkg::OP_ALU_IMM, rex_wb};
                desc.hdr_len = 3'd3;
            end
            x86e_pkg::CMD_SUBIMM: begin
                desc.hdr     = {8'h00, x86e_pkg::MOD_REG, x86e_pkg::EXT_SUB, m,
                                x86e_pkg::OP_ALU_IMM, rex_wb};
                desc.hdr_len = 3'd3;
            end
            x86e_pkg::CMD_CALLREG: begin
                desc.imm_len = 4'd0;
                if (bb) begin
                    desc.hdr     = {8'h00, x86e_pkg::MOD_REG, x86e_pkg::EXT_CALL, m,
                                    x86e_pkg::OP_GRP5, x86e_pkg::REX_B_ONLY};
                    desc.hdr_len = 3'd3;
                end else begin
                    desc.hdr     = {16'h0000, x86e_pkg::MOD_REG, x86e_pkg::EXT_CALL, m,
                                    x86e_pkg::OP_GRP5};
                    desc.hdr_len = 3'd2;
                end
            end
            x86e_pkg::CMD_CALLREL: begin
                desc.hdr = {24'h000000, x86e_pkg::OP_CALL_REL};
            end
            x86e_pkg::CMD_RET: begin
                desc.hdr     = {24'h000000, x86e_pkg::OP_RET};
                desc.imm_len = 4'd0;
            end
            x86e_pkg::CMD_PUSH, x86e_pkg::CMD_POP: begin
                desc.imm_len = 4'd0;
                if (command == x86e_pkg::CMD_PUSH) begin
                    desc.hdr = {16'h0000, x86e_pkg::OP_PUSH_HI, m, x86e_pkg::REX_B_ONLY};
                end else begin
                    desc.hdr = {16'h0000, x86e_pkg::OP_POP_HI, m, x86e_pkg::REX_B_ONLY};
                end
                if (bb) begin
                    desc.hdr_len = 3'd2;
                end else begin
                    desc.hdr     = desc.hdr >> 8;
                    desc.hdr_len = 3'd1;
                end
            end
            x86e_pkg::CMD_JCC: begin
                desc.hdr     = {16'h0000, x86e_pkg::OP_JCC_HI, condition, x86e_pkg::OP_ESCAPE};
                desc.hdr_len = 3'd2;
            end
            x86e_pkg::CMD_JMP: begin
                desc.hdr = {24'h000000, x86e_pkg::OP_JMP_REL};
            end
            x86e_pkg::CMD_STORE, x86e_pkg::CMD_LOAD: begin
                desc.imm_len = 4'd1;
                desc.hdr     = {x86e_pkg::SIB_RSP_BASE, modrm_mem,
                                (command == x86e_pkg::CMD_STORE) ? x86e_pkg::OP_MOV_STORE
                                                                 : x86e_pkg::OP_MOV_LOAD,
                                rex_wrb};
                desc.hdr_len = (m == x86e_pkg::RM_SIB) ? 3'd4 : 3'd3;
            end
            default: begin
                desc.hdr_len = 3'd1;
            end
        endcase
    end

endmodule

// ===== rtl/x86e_queue.sv =====
// Descriptor queue between the front classifier and the byte serializer.
// Small circular buffer of x86e_pkg::desc_t entries with an occupancy count.
module x86e_queue #(
    parameter int DEPTH = x86e_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  x86e_pkg::desc_t in_desc,
    output logic            out_valid,
    input  logic            out_ready,
    output x86e_pkg::desc_t out_desc
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    x86e_pkg::desc_t entries [DEPTH];

    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push;
    logic          pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_desc  = entries[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= in_desc;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue occupancy above depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

// ===== rtl/x86e_back.sv =====
// Byte serializer: takes descriptors from the queue and shifts out header
// bytes, then immediate bytes, through a registered output stage. Uses x86e_pkg.
module x86e_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  x86e_pkg::desc_t q_desc,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,  // code_byte
    output logic            m_tlast
);

    logic        busy_reg;
    logic        busy_next;
    logic [31:0] hdr_reg;
    logic [31:0] hdr_next;
    logic [2:0]  hdr_cnt_reg;
    logic [2:0]  hdr_cnt_next;
    logic [63:0] imm_reg;
    logic [63:0] imm_next;
    logic [3:0]  imm_cnt_reg;
    logic [3:0]  imm_cnt_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [7:0]  m_tdata_reg;
    logic [7:0]  m_tdata_next;
    logic        m_tlast_reg;
    logic        m_tlast_next;

    logic [3:0]  remaining;
    logic        advance;
    logic        emit;
    logic        emit_last;
    logic        load;
    logic [7:0]  cur_byte;

    assign remaining = {1'b0, hdr_cnt_reg} + imm_cnt_reg;
    assign advance   = !m_tvalid_reg || m_tready;
    assign emit      = busy_reg && advance;
    assign emit_last = emit && (remaining == 4'd1);
    assign load      = q_valid && (!busy_reg || emit_last);
    assign q_ready   = !busy_reg || emit_last;
    assign cur_byte  = (hdr_cnt_reg != '0) ? hdr_reg[7:0] : imm_reg[7:0];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        busy_next     = busy_reg;
        hdr_next      = hdr_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        imm_next      = imm_reg;
        imm_cnt_next  = imm_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (advance) begin
            m_tvalid_next = busy_reg;
            m_tdata_next  = cur_byte;
            m_tlast_next  = (remaining == 4'd1);
        end

        if (emit) begin
            if (hdr_cnt_reg != '0) begin
                hdr_next     = hdr_reg >> 8;
                hdr_cnt_next = hdr_cnt_reg - 1'b1;
            end else begin
                imm_next     = imm_reg >> 8;
                imm_cnt_next = imm_cnt_reg - 1'b1;
            end
        end

        if (load) begin
            busy_next    = 1'b1;
            hdr_next     = q_desc.hdr;
            hdr_cnt_next = q_desc.hdr_len;
            imm_next     = q_desc.imm;
            imm_cnt_next = q_desc.imm_len;
        end else if (emit_last) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            hdr_cnt_reg  <= '0;
            imm_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            imm_cnt_reg  <= imm_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_reg     <= hdr_next;
        imm_reg     <= imm_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (remaining != 4'd0))
        else $error("serializer busy with no bytes left");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && busy_reg) |-> emit_last)
        else $error("descriptor loaded over an unfinished instruction");

endmodule
